// ===== design/rba_pkg.sv =====
// shared types and register codes for the angular acceleration block
`timescale 1ns / 1ps
`default_nettype none

package rba_pkg;

    typedef enum logic {
        CFG_PREDICTOR = 1'b0,
        CFG_COUPLING  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic tneg;
        logic zero;
        logic neg2;
    } t_axis_flags;

    localparam int AXES = 3;
    localparam int FLAG_BITS = AXES * $bits(t_axis_flags);

endpackage

`default_nettype wire

// ===== design/rigid_body_angular_acceleration.sv =====
// top level: rigid body angular acceleration from euler's equations
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+----------------------------------
//  input    | in        | i_valid / o_stall         | torque, omega, inertia vectors
//  result   | out       | o_valid / i_stall         | accel vector, overflow
//  config   | in        | i_cfg_valid / o_cfg_ready | register index, data
//
// one word accepted per cycle while o_stall is low; the divider pipelines
// resolve one quotient bit per stage.
// reset clears valid bits and sets predictor mode and a coupling factor of 1.0.
// a stall while a result word waits freezes the whole pipeline and raises o_stall.
`timescale 1ns / 1ps
`default_nettype none

module rigid_body_angular_acceleration import rba_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [WORD_BITS-1:0]  i_torque_x,
    input  wire logic signed [WORD_BITS-1:0]  i_torque_y,
    input  wire logic signed [WORD_BITS-1:0]  i_torque_z,
    input  wire logic signed [WORD_BITS-1:0]  i_omega_x,
    input  wire logic signed [WORD_BITS-1:0]  i_omega_y,
    input  wire logic signed [WORD_BITS-1:0]  i_omega_z,
    input  wire logic [WORD_BITS-1:0]         i_inertia_xx,
    input  wire logic [WORD_BITS-1:0]         i_inertia_yy,
    input  wire logic [WORD_BITS-1:0]         i_inertia_zz,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [WORD_BITS-1:0]       o_accel_x,
    output logic signed [WORD_BITS-1:0]       o_accel_y,
    output logic signed [WORD_BITS-1:0]       o_accel_z,
    output logic                              o_overflow,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_index,
    input  wire logic [WORD_BITS-1:0]         i_cfg_data
);

    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int S = W + 3;
    localparam logic signed [S-1:0] MAXV = {{4{1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [S-1:0] MINV = {{4{1'b1}}, {(W-1){1'b0}}};

    logic                       r_pred;
    logic [W-1:0]               r_coupling;
    logic                       en;

    logic                       prod_v;
    logic [AXES-1:0][W+2*F-1:0] num1;
    logic [AXES-1:0][2*W-1:0]   den1;
    logic [AXES-1:0][3*W-1:0]   num2;
    logic [AXES-1:0][W+F-1:0]   den2;
    t_axis_flags [AXES-1:0]     prod_flags;

    logic                       div1_v, div2_v;
    logic [AXES-1:0][W:0]       quo1, quo2;
    logic [FLAG_BITS-1:0]       side1;
    logic                       side2;
    t_axis_flags [AXES-1:0]     flags;

    logic [AXES-1:0][W-1:0]     n_accel;
    logic [AXES-1:0]            n_ovf;

    logic                       r_ov;
    logic [AXES-1:0][W-1:0]     r_accel;
    logic                       r_ovf;

    assign en          = !r_ov || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred     <= 1'b1;
            r_coupling <= {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PREDICTOR: r_pred     <= i_cfg_data[0];
                CFG_COUPLING:  r_coupling <= i_cfg_data;
                default:       r_pred     <= r_pred;
            endcase
        end
    end

    rba_prod #(.W(W), .F(F)) u_prod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_coupling (r_coupling),
        .i_torque   ({i_torque_z, i_torque_y, i_torque_x}),
        .i_omega    ({i_omega_z, i_omega_y, i_omega_x}),
        .i_inertia  ({i_inertia_zz, i_inertia_yy, i_inertia_xx}),
        .o_valid    (prod_v),
        .o_num1     (num1),
        .o_den1     (den1),
        .o_num2     (num2),
        .o_den2     (den2),
        .o_flags    (prod_flags)
    );

    rba_div #(.LANES(AXES), .NW(W+2*F), .DW(2*W), .QW(W), .SW(FLAG_BITS)) u_div_torque (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prod_v),
        .i_num   (num1),
        .i_den   (den1),
        .i_side  (prod_flags),
        .o_valid (div1_v),
        .o_quo   (quo1),
        .o_side  (side1)
    );

    rba_div #(.LANES(AXES), .NW(3*W), .DW(W+F), .QW(W), .SW(1)) u_div_gyro (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prod_v),
        .i_num   (num2),
        .i_den   (den2),
        .i_side  (r_pred),
        .o_valid (div2_v),
        .o_quo   (quo2),
        .o_side  (side2)
    );

    assign flags = side1;

    for (genvar a = 0; a < AXES; a++) begin : g_sum
        logic signed [S-1:0] t1, t2, sum;
        always_comb begin
            t1 = {2'b00, quo1[a]};
            if (flags[a].tneg) t1 = -t1;
            t2 = side2 ? {2'b00, quo2[a]} : '0;
            if (flags[a].neg2) t2 = -t2;
            sum = t1 + t2;
            n_ovf[a] = quo1[a][W] || (side2 && quo2[a][W]);
            if (flags[a].zero) begin
                n_accel[a] = flags[a].tneg ? MINV[W-1:0] : MAXV[W-1:0];
                n_ovf[a]   = 1'b1;
            end else if (sum > MAXV) begin
                n_accel[a] = MAXV[W-1:0];
                n_ovf[a]   = 1'b1;
            end else if (sum < MINV) begin
                n_accel[a] = MINV[W-1:0];
                n_ovf[a]   = 1'b1;
            end else begin
                n_accel[a] = sum[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= div1_v && div2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_accel <= n_accel;
            r_ovf   <= |n_ovf;
        end
    end

    assign o_valid    = r_ov;
    assign o_accel_x  = r_accel[0];
    assign o_accel_y  = r_accel[1];
    assign o_accel_z  = r_accel[2];
    assign o_overflow = r_ovf;

endmodule

`default_nettype wire

// ===== design/rba_prod.sv =====
// front stages: magnitudes, signs and the products that feed the dividers
`timescale 1ns / 1ps
`default_nettype none

module rba_prod import rba_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [W-1:0]                   i_coupling,
    input  wire logic [AXES-1:0][W-1:0]         i_torque,
    input  wire logic [AXES-1:0][W-1:0]         i_omega,
    input  wire logic [AXES-1:0][W-1:0]         i_inertia,
    output logic                                o_valid,
    output logic [AXES-1:0][W+2*F-1:0]          o_num1,
    output logic [AXES-1:0][2*W-1:0]            o_den1,
    output logic [AXES-1:0][3*W-1:0]            o_num2,
    output logic [AXES-1:0][W+F-1:0]            o_den2,
    output t_axis_flags [AXES-1:0]              o_flags
);

    logic                       r1_v, r2_v, r3_v;
    logic [AXES-1:0][W-1:0]     r1_tmag, r2_tmag, r3_tmag;
    logic [AXES-1:0][W-1:0]     r1_ii, r2_ii, r3_ii;
    logic [AXES-1:0][2*W-1:0]   r1_den1, r2_den1, r3_den1;
    t_axis_flags [AXES-1:0]     r1_flags, r2_flags, r3_flags;
    logic [AXES-1:0][2*W-1:0]   r1_mw;
    logic [AXES-1:0][W-1:0]     r1_dmag;
    logic [AXES-1:0][2*W-1:0]   r2_plo, r2_phi;
    logic [AXES-1:0][3*W-1:0]   r3_num2;

    logic [AXES-1:0][W-1:0]     n1_tmag, n1_dmag, n1_wmag;
    logic [AXES-1:0][2*W-1:0]   n1_mw, n1_den1;
    t_axis_flags [AXES-1:0]     n1_flags;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        localparam int J = (a + 1) % AXES;
        localparam int K = (a + 2) % AXES;
        logic [W:0] dif;
        always_comb begin
            dif = {1'b0, i_inertia[J]} - {1'b0, i_inertia[K]};
            n1_tmag[a] = i_torque[a][W-1] ? W'(-i_torque[a]) : i_torque[a];
            n1_dmag[a] = dif[W] ? W'(-dif) : dif[W-1:0];
            n1_wmag[a] = i_omega[a][W-1] ? W'(-i_omega[a]) : i_omega[a];
            n1_flags[a].tneg = i_torque[a][W-1];
            n1_flags[a].zero = (i_inertia[a] == '0) || (i_coupling == '0);
            n1_flags[a].neg2 = i_omega[J][W-1] ^ i_omega[K][W-1] ^ dif[W];
            n1_den1[a] = (2*W)'(i_coupling) * (2*W)'(i_inertia[a]);
        end
    end

    // omega magnitudes need all lanes first
    for (genvar a = 0; a < AXES; a++) begin : g_mw
        localparam int J = (a + 1) % AXES;
        localparam int K = (a + 2) % AXES;
        assign n1_mw[a] = (2*W)'(n1_wmag[J]) * (2*W)'(n1_wmag[K]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tmag  <= n1_tmag;
            r1_ii    <= i_inertia;
            r1_den1  <= n1_den1;
            r1_flags <= n1_flags;
            r1_mw    <= n1_mw;
            r1_dmag  <= n1_dmag;
            for (int a = 0; a < AXES; a++) begin
                r2_plo[a] <= (2*W)'(r1_mw[a][W-1:0]) * (2*W)'(r1_dmag[a]);
                r2_phi[a] <= (2*W)'(r1_mw[a][2*W-1:W]) * (2*W)'(r1_dmag[a]);
                r3_num2[a] <= (3*W)'(r2_plo[a]) + {r2_phi[a][2*W-1:0], {W{1'b0}}};
            end
            r2_tmag  <= r1_tmag;
            r2_ii    <= r1_ii;
            r2_den1  <= r1_den1;
            r2_flags <= r1_flags;
            r3_tmag  <= r2_tmag;
            r3_ii    <= r2_ii;
            r3_den1  <= r2_den1;
            r3_flags <= r2_flags;
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_num1[a] = {r3_tmag[a], {(2*F){1'b0}}};
            o_den2[a] = {r3_ii[a], {F{1'b0}}};
        end
    end

    assign o_valid = r3_v;
    assign o_den1  = r3_den1;
    assign o_num2  = r3_num2;
    assign o_flags = r3_flags;

endmodule

`default_nettype wire

// ===== design/rba_div.sv =====
// pipelined restoring divider, one quotient bit per stage, clamped at 2^QW
`timescale 1ns / 1ps
`default_nettype none

module rba_div #(
    parameter int LANES = 3,
    parameter int NW    = 64,
    parameter int DW    = 64,
    parameter int QW    = 32,
    parameter int SW    = 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [LANES-1:0][NW-1:0]       i_num,
    input  wire logic [LANES-1:0][DW-1:0]       i_den,
    input  wire logic [SW-1:0]                  i_side,
    output logic                                o_valid,
    output logic [LANES-1:0][QW:0]              o_quo,
    output logic [SW-1:0]                       o_side
);

    localparam int XW = (NW > DW + QW) ? NW : DW + QW;

    logic                         r_v    [0:QW];
    logic [SW-1:0]                r_side [0:QW];
    logic [LANES-1:0][XW-1:0]     r_rem  [0:QW];
    logic [LANES-1:0][DW-1:0]     r_den  [0:QW];
    logic [LANES-1:0][QW-1:0]     r_q    [0:QW];
    logic [LANES-1:0]             r_sat  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= QW; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r_rem[0][l] <= XW'(i_num[l]);
                r_den[0][l] <= i_den[l];
                r_q[0][l]   <= '0;
                r_sat[0][l] <= XW'(i_num[l]) >= (XW'(i_den[l]) << QW);
            end
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_stage
        localparam int B = QW - s;
        logic [LANES-1:0][XW-1:0] trial;
        logic [LANES-1:0]         take;
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = XW'(r_den[s-1][l]) << B;
                take[l]  = !r_sat[s-1][l] && (r_rem[s-1][l] >= trial[l]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= r_side[s-1];
                for (int l = 0; l < LANES; l++) begin
                    r_den[s][l] <= r_den[s-1][l];
                    r_sat[s][l] <= r_sat[s-1][l];
                    r_rem[s][l] <= take[l] ? r_rem[s-1][l] - trial[l] : r_rem[s-1][l];
                    r_q[s][l]   <= r_q[s-1][l] | (QW'(take[l]) << B);
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_sat[QW][l] ? {1'b1, {QW{1'b0}}} : {1'b0, r_q[QW][l]};
        end
    end

    assign o_valid = r_v[QW];
    assign o_side  = r_side[QW];

endmodule

`default_nettype wire
